// ===== rtl/mcid_pkg.sv =====
// Package: shared constants for the multi-channel input debouncer.
`timescale 1ns / 1ps
package mcid_pkg;
	localparam int CHANNELS = 8;
	localparam int CH_W = 3;
	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int TIME_W = 32;
	localparam int DELAY_W = 16;
	localparam int MASK_W = 8;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd50;
	localparam logic [MASK_W-1:0] MASK_RESET = 8'd0;

	typedef enum logic {
		REG_HOLD_TICKS = 1'b0,
		REG_INVERT_MASK = 1'b1
	} reg_index_t;
endpackage

// ===== rtl/mcid_sample_if.sv =====
// Interfaces: sample and result channels of the debouncer.
`timescale 1ns / 1ps
interface mcid_sample_if;
	import mcid_pkg::*;
	logic valid;
	logic ready;
	logic [CH_W-1:0] channel;
	logic raw_level;
	logic [TIME_W-1:0] now_ms;
	modport source (output valid, output channel, output raw_level, output now_ms,
		input ready);
	modport sink (input valid, input channel, input raw_level, input now_ms,
		output ready);
endinterface

interface mcid_result_if;
	import mcid_pkg::*;
	logic valid;
	logic ready;
	logic [CH_W-1:0] out_channel;
	logic stable_level;
	logic changed;
	logic [TIME_W-1:0] change_interval;
	modport source (output valid, output out_channel, output stable_level,
		output changed, output change_interval, input ready);
	modport sink (input valid, input out_channel, input stable_level,
		input changed, input change_interval, output ready);
endinterface

// ===== rtl/multi_channel_input_debouncer.sv =====
// Top level: per-channel debouncer with change pulse and change interval.
// A sample passes through the input register and then the result register before its result is offered.
// Throughput: one item per cycle while results are accepted; each item is resolved by one state lookup and update.
// A stalled result holds the result register and one item in the input register.
// Reset (arst_n low, asynchronous) clears all channel state to zero, the hold delay to 50
// and invert_mask to zero.
`timescale 1ns / 1ps
module multi_channel_input_debouncer
	import mcid_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	mcid_sample_if.sink samples,
	mcid_result_if.source results,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic pready
);

	logic [DELAY_W-1:0] hold_ticks_q;
	logic [MASK_W-1:0] invert_mask_q;
	reg_index_t reg_sel;

	logic cand_level_q [CHANNELS];
	logic [TIME_W-1:0] cand_time_q [CHANNELS];
	logic stable_q [CHANNELS];
	logic [TIME_W-1:0] last_change_q [CHANNELS];

	logic valid_s1;
	logic [CH_W-1:0] channel_s1;
	logic raw_level_s1;
	logic [TIME_W-1:0] now_ms_s1;

	logic valid_s2;
	logic [CH_W-1:0] out_channel_s2;
	logic stable_level_s2;
	logic changed_s2;
	logic [TIME_W-1:0] change_interval_s2;

	logic advance;
	logic in_range;
	logic [IDX_W-1:0] idx;
	logic level;
	logic [TIME_W-1:0] held;
	logic restart;
	logic promote;
	logic next_stable;
	logic [TIME_W-1:0] interval;

	assign pready = 1'b1;
	assign reg_sel = reg_index_t'(paddr[2]);

	always_comb begin
		unique case (reg_sel)
			REG_HOLD_TICKS: prdata = DATA_W'(hold_ticks_q);
			REG_INVERT_MASK: prdata = DATA_W'(invert_mask_q);
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ticks_q <= DELAY_RESET;
			invert_mask_q <= MASK_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_sel)
				REG_HOLD_TICKS: hold_ticks_q <= pwdata[DELAY_W-1:0];
				REG_INVERT_MASK: invert_mask_q <= pwdata[MASK_W-1:0];
				default: ;
			endcase
		end
	end

	// advance the input register into the result register
	assign advance = valid_s1 && (!valid_s2 || results.ready);
	assign samples.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.ready && samples.valid) begin
			channel_s1 <= samples.channel;
			raw_level_s1 <= samples.raw_level;
			now_ms_s1 <= samples.now_ms;
		end
	end

	always_comb begin
		in_range = int'(channel_s1) < CHANNELS;
		idx = IDX_W'(channel_s1);
		level = raw_level_s1 ^ invert_mask_q[channel_s1];
		held = now_ms_s1 - cand_time_q[idx];
		restart = in_range && (level != cand_level_q[idx]);
		promote = in_range && !restart && (held > TIME_W'(hold_ticks_q))
			&& (level != stable_q[idx]);
		next_stable = promote ? level : stable_q[idx];
		interval = promote ? (now_ms_s1 - last_change_q[idx]) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				cand_level_q[c] <= 1'b0;
				cand_time_q[c] <= '0;
				stable_q[c] <= 1'b0;
				last_change_q[c] <= '0;
			end
		end else if (advance) begin
			if (restart) begin
				cand_level_q[idx] <= level;
				cand_time_q[idx] <= now_ms_s1;
			end
			if (promote) begin
				stable_q[idx] <= level;
				last_change_q[idx] <= now_ms_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || results.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_channel_s2 <= channel_s1;
			stable_level_s2 <= in_range && next_stable;
			changed_s2 <= promote;
			change_interval_s2 <= interval;
		end
	end

	assign results.valid = valid_s2;
	assign results.out_channel = out_channel_s2;
	assign results.stable_level = stable_level_s2;
	assign results.changed = changed_s2;
	assign results.change_interval = change_interval_s2;

`ifndef NO_ASSERTIONS
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !results.ready |-> !samples.ready)
		else $error("input accepted while both stages stalled");

	a_interval_only_on_change: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !changed_s2 |-> change_interval_s2 == '0)
		else $error("nonzero change interval without a change");

	a_change_committed: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && changed_s2 |-> stable_q[IDX_W'(out_channel_s2)] == stable_level_s2)
		else $error("reported change not held in channel state");
`endif

endmodule

// ===== tb/sv/multi_channel_input_debouncer_tb.sv =====
// Testbench: debouncer driven by table and random samples, results checked in order of issue.
`timescale 1ns / 1ps
module multi_channel_input_debouncer_tb;
	import mcid_pkg::*;

	localparam int ITEMS_PER_PHASE = 130;
	localparam int PHASES = 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DIRECTED_ROWS = 23;

	typedef struct packed {
		logic [CH_W-1:0] out_channel;
		logic stable_level;
		logic changed;
		logic [TIME_W-1:0] change_interval;
	} debounce_result_t;

	typedef struct packed {
		logic [CH_W-1:0] ch;
		logic lvl;
		logic [TIME_W-1:0] now;
		logic typed;
		logic stable;
		logic chg;
		logic [TIME_W-1:0] interval;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	mcid_sample_if samples_if();
	mcid_result_if results_if();

	multi_channel_input_debouncer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples_if),
		.results(results_if),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	logic [DELAY_W-1:0] delay_cfg = DELAY_RESET;
	logic [MASK_W-1:0] mask_cfg = MASK_RESET;
	logic cand_level [CHANNELS] = '{default: 1'b0};
	logic [TIME_W-1:0] cand_time [CHANNELS] = '{default: '0};
	logic stable_q [CHANNELS] = '{default: 1'b0};
	logic [TIME_W-1:0] last_change [CHANNELS] = '{default: '0};

	debounce_result_t channel_updates [$];
	row_t directed [DIRECTED_ROWS];
	int mismatch_count = 0;
	int cycle_count = 0;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic debounce_result_t debounce_update(input logic [CH_W-1:0] ch,
		input logic lvl, input logic [TIME_W-1:0] now);
		debounce_result_t r;
		logic eff;
		logic [TIME_W-1:0] held;
		r = '0;
		r.out_channel = ch;
		if (int'(ch) < CHANNELS) begin
			eff = lvl ^ mask_cfg[ch];
			if (eff != cand_level[ch]) begin
				cand_level[ch] = eff;
				cand_time[ch] = now;
			end else begin
				held = now - cand_time[ch];
				if (held > TIME_W'(delay_cfg) && eff != stable_q[ch]) begin
					stable_q[ch] = eff;
					r.change_interval = now - last_change[ch];
					last_change[ch] = now;
					r.changed = 1'b1;
				end
			end
			r.stable_level = stable_q[ch];
		end
		return r;
	endfunction

	task automatic send_item(input logic [CH_W-1:0] ch, input logic lvl,
		input logic [TIME_W-1:0] now, input logic typed, input debounce_result_t typed_res);
		debounce_result_t predicted;
		while ($urandom_range(99) < sender_idle_pct) begin
			samples_if.valid <= 1'b0;
			@(negedge clk);
		end
		samples_if.valid <= 1'b1;
		samples_if.channel <= ch;
		samples_if.raw_level <= lvl;
		samples_if.now_ms <= now;
		@(posedge clk);
		while (!samples_if.ready) @(posedge clk);
		predicted = debounce_update(ch, lvl, now);
		channel_updates.push_back(typed ? typed_res : predicted);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		samples_if.valid <= 1'b0;
		while (channel_updates.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			REG_HOLD_TICKS: begin
				delay_cfg = value[DELAY_W-1:0];
			end
			REG_INVERT_MASK: begin
				mask_cfg = value[MASK_W-1:0];
			end
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	always @(negedge clk) begin
		results_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	always @(posedge clk) begin
		debounce_result_t want;
		if (arst_n && results_if.valid && results_if.ready) begin
			if (channel_updates.size() == 0) begin
				$error("unexpected item on channel %0d", results_if.out_channel);
				mismatch_count++;
			end else begin
				want = channel_updates.pop_front();
				if (results_if.out_channel !== want.out_channel) begin
					$error("out_channel: expected %0d, got %0d", want.out_channel,
						results_if.out_channel);
					mismatch_count++;
				end
				if (results_if.stable_level !== want.stable_level) begin
					$error("stable_level: expected %0d, got %0d", want.stable_level,
						results_if.stable_level);
					mismatch_count++;
				end
				if (results_if.changed !== want.changed) begin
					$error("changed: expected %0d, got %0d", want.changed,
						results_if.changed);
					mismatch_count++;
				end
				if (results_if.change_interval !== want.change_interval) begin
					$error("change_interval: expected %0d, got %0d", want.change_interval,
						results_if.change_interval);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		int p;
		int n;
		int k;
		int len;
		int r;
		logic [CH_W-1:0] ch;
		logic lvl;
		logic item_lvl;
		logic [TIME_W-1:0] now;
		logic [TIME_W-1:0] cur;
		logic [TIME_W-1:0] dly;
		debounce_result_t typed_res;
		logic [DELAY_W-1:0] phase_delay [PHASES];
		logic [MASK_W-1:0] phase_mask [PHASES];

		phase_delay = '{16'd0, 16'd65535, 16'd3, 16'd50, 16'd1000, 16'd1, 16'd17, 16'd200};
		phase_mask = '{8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h0F, 8'hF0, 8'h3C, 8'h81};
		directed = '{
			'{3'd0, 1'b0, 32'd0, 1'b1, 1'b0, 1'b0, 32'd0},
			'{3'd0, 1'b1, 32'd10, 1'b1, 1'b0, 1'b0, 32'd0},
			'{3'd0, 1'b1, 32'd60, 1'b1, 1'b0, 1'b0, 32'd0},
			'{3'd0, 1'b1, 32'd61, 1'b1, 1'b1, 1'b1, 32'd61},
			'{3'd0, 1'b1, 32'd100, 1'b1, 1'b1, 1'b0, 32'd0},
			'{3'd0, 1'b0, 32'd200, 1'b1, 1'b1, 1'b0, 32'd0},
			'{3'd0, 1'b0, 32'd251, 1'b1, 1'b0, 1'b1, 32'd190},
			'{3'd7, 1'b1, 32'hFFFF_FFF0, 1'b1, 1'b0, 1'b0, 32'd0},
			'{3'd7, 1'b1, 32'h0000_0023, 1'b1, 1'b1, 1'b1, 32'd35},
			'{3'd3, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 32'd0},
			'{3'd3, 1'b1, 32'h0000_0032, 1'b1, 1'b1, 1'b1, 32'd50},
			'{3'd1, 1'b1, 32'd1000, 1'b0, 1'b0, 1'b0, 32'd0},
			'{3'd2, 1'b1, 32'd1000, 1'b0, 1'b0, 1'b0, 32'd0},
			'{3'd4, 1'b1, 32'd1000, 1'b0, 1'b0, 1'b0, 32'd0},
			'{3'd5, 1'b1, 32'd1000, 1'b0, 1'b0, 1'b0, 32'd0},
			'{3'd6, 1'b1, 32'd1000, 1'b0, 1'b0, 1'b0, 32'd0},
			'{3'd1, 1'b1, 32'd1051, 1'b0, 1'b0, 1'b0, 32'd0},
			'{3'd2, 1'b1, 32'd1050, 1'b0, 1'b0, 1'b0, 32'd0},
			'{3'd4, 1'b0, 32'd1100, 1'b0, 1'b0, 1'b0, 32'd0},
			'{3'd4, 1'b1, 32'd1200, 1'b0, 1'b0, 1'b0, 32'd0},
			'{3'd5, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 32'd0},
			'{3'd6, 1'b0, 32'd2000, 1'b0, 1'b0, 1'b0, 32'd0},
			'{3'd3, 1'b0, 32'hAAAA_5555, 1'b0, 1'b0, 1'b0, 32'd0}
		};

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		samples_if.valid = 1'b0;
		samples_if.channel = '0;
		samples_if.raw_level = 1'b0;
		samples_if.now_ms = '0;
		results_if.ready = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[i]) begin
			typed_res = '{directed[i].ch, directed[i].stable, directed[i].chg,
				directed[i].interval};
			send_item(directed[i].ch, directed[i].lvl, directed[i].now, directed[i].typed,
				typed_res);
		end

		for (p = 0; p < PHASES; p++) begin
			wait_drained();
			repeat (4) @(negedge clk);
			write_reg(REG_HOLD_TICKS, DATA_W'(phase_delay[p]));
			write_reg(REG_INVERT_MASK, DATA_W'(phase_mask[p]));
			case (p % 4)
				0: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 61;
					receiver_stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 61;
				end
				default: begin
					sender_idle_pct = 37;
					receiver_stall_pct = 37;
				end
			endcase
			dly = TIME_W'(delay_cfg);
			cur = (p % 3 == 1) ? 32'hFFFF_0000 : $urandom();
			n = 0;
			while (n < ITEMS_PER_PHASE) begin
				ch = CH_W'($urandom_range(CHANNELS - 1));
				lvl = 1'($urandom_range(1));
				len = $urandom_range(1, 6);
				for (k = 0; k < len && n < ITEMS_PER_PHASE; k++) begin
					item_lvl = ($urandom_range(99) < 15) ? ~lvl : lvl;
					r = $urandom_range(99);
					if (r < 30) begin
						now = cur + TIME_W'($urandom_range(0, int'(dly / 4) + 1));
					end else if (r < 55) begin
						now = cand_time[ch] + dly + TIME_W'($urandom_range(0, 1));
					end else if (r < 65) begin
						now = $urandom();
					end else begin
						now = cur + TIME_W'($urandom_range(0, 2 * int'(dly) + 4));
					end
					cur = now;
					send_item(ch, item_lvl, now, 1'b0, '0);
					n++;
					if (n == ITEMS_PER_PHASE / 2 && p % 2 == 1) begin
						wait_drained();
					end
				end
			end
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
